// ===== hw/rtl/lfbl_pkg.sv =====
// shared types and constants for the linked free block list
// no dependencies
package lfbl_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);

  typedef enum logic [1:0] {
    ACT_POP    = 2'd0,
    ACT_PUSH   = 2'd1,
    ACT_FORMAT = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_INVALID = 2'd2,
    STAT_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_POP
  } state_e;

  // one access to the link memory per cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/lfbl_link_ram.sv =====
// next-link store: single port synchronous ram, registered read data
// depends on lfbl_pkg
module lfbl_link_ram
  import lfbl_pkg::*;
(
  input  logic             clk_i,
  input  mem_req_t         req_i,
  output logic [IDX_W-1:0] rdata_o
);

  logic [IDX_W-1:0] mem [NUM_BLOCKS];
  logic [IDX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.addr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lfbl_ctrl.sv =====
// sequencer for pop, push and format, plus head, count and result registers
// depends on lfbl_pkg; drives the link ram request
module lfbl_ctrl
  import lfbl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [IDX_W-1:0] block_index_i,
  output logic             valid_o,
  output logic [IDX_W-1:0] given_block_o,
  output logic [1:0]       status_o,
  output logic [IDX_W-1:0] free_count_o,
  output mem_req_t         mem_req_o,
  input  logic [IDX_W-1:0] mem_rdata_i
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] head_q, head_d;
  logic [IDX_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic             fmt_q, fmt_d;
  logic             valid_q, valid_d;
  logic [IDX_W-1:0] given_q, given_d;
  status_e          status_q, status_d;
  logic             is_empty, bad_block;

  assign is_empty  = (head_q == '0) || (count_q == '0);
  assign bad_block = (block_index_i == '0) ||
                     ((IDX_W+1)'(block_index_i) >= (IDX_W+1)'(NUM_BLOCKS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_SWEEP;
      head_q   <= IDX_W'(1);
      count_q  <= LAST_IDX;
      sweep_q  <= '0;
      fmt_q    <= 1'b0;
      valid_q  <= 1'b0;
      given_q  <= '0;
      status_q <= STAT_OK;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      sweep_q  <= sweep_d;
      fmt_q    <= fmt_d;
      valid_q  <= valid_d;
      given_q  <= given_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    sweep_d   = sweep_q;
    fmt_d     = fmt_q;
    valid_d   = 1'b0;
    given_d   = given_q;
    status_d  = status_q;
    busy      = 1'b1;
    mem_req_o = '{we: 1'b0, addr: head_q, wdata: head_q};

    case (state_q)
      S_SWEEP: begin
        // rebuild the chain one entry per cycle
        mem_req_o.we    = 1'b1;
        mem_req_o.addr  = sweep_q;
        mem_req_o.wdata = (sweep_q == LAST_IDX) ? '0 : sweep_q + IDX_W'(1);
        sweep_d         = sweep_q + IDX_W'(1);
        if (sweep_q == LAST_IDX) begin
          head_d  = IDX_W'(1);
          count_d = LAST_IDX;
          state_d = S_IDLE;
          fmt_d   = 1'b0;
          if (fmt_q) begin
            valid_d  = 1'b1;
            given_d  = '0;
            status_d = STAT_OK;
          end
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          given_d  = '0;
          status_d = STAT_OK;
          case (action_e'(action_i))
            ACT_POP: begin
              if (is_empty) begin
                valid_d  = 1'b1;
                status_d = STAT_EMPTY;
              end else begin
                // read link of current head, finish next cycle
                state_d = S_POP;
              end
            end
            ACT_PUSH: begin
              valid_d = 1'b1;
              if (bad_block) begin
                status_d = STAT_INVALID;
              end else if (count_q >= LAST_IDX) begin
                status_d = STAT_FULL;
              end else begin
                mem_req_o.we    = 1'b1;
                mem_req_o.addr  = block_index_i;
                mem_req_o.wdata = head_q;
                head_d          = block_index_i;
                count_d         = count_q + IDX_W'(1);
              end
            end
            ACT_FORMAT: begin
              sweep_d = '0;
              fmt_d   = 1'b1;
              state_d = S_SWEEP;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        valid_d  = 1'b1;
        given_d  = head_q;
        status_d = STAT_OK;
        head_d   = mem_rdata_i;
        count_d  = count_q - IDX_W'(1);
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign valid_o       = valid_q;
  assign given_block_o = given_q;
  assign status_o      = status_q;
  assign free_count_o  = count_q;

endmodule

// ===== hw/rtl/linked_free_block_list.sv =====
// linked free block list allocator: top level
// depends on lfbl_pkg, lfbl_ctrl, lfbl_link_ram
//
//   channel   handshake         payload
//   command   start / busy      action_i, block_index_i
//   result    valid_o (strobe)  given_block_o, status_o, free_count_o
//
// push, empty pop and the unused action are handled in the idle state; the result strobes on the next cycle
// a pop that hands out a block does a link ram read, then the head update
// format sweeps the link ram one entry per cycle over all NUM_BLOCKS entries, busy throughout
// after reset the same sweep runs (no result) before start is taken
// the result is held for one cycle only; the receiver cannot stall it
module linked_free_block_list
  import lfbl_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       action_i,
  input  logic [IDX_W-1:0] block_index_i,
  output logic             valid_o,
  output logic [IDX_W-1:0] given_block_o,
  output logic [1:0]       status_o,
  output logic [IDX_W-1:0] free_count_o
);

  mem_req_t         mem_req;
  logic [IDX_W-1:0] mem_rdata;

  lfbl_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .block_index_i (block_index_i),
    .valid_o       (valid_o),
    .given_block_o (given_block_o),
    .status_o      (status_o),
    .free_count_o  (free_count_o),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  lfbl_link_ram u_link_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== dv/tb_linked_free_block_list.sv =====
// testbench for linked_free_block_list: directed table then random pop/push/format traffic
// results are checked against table values or a behavioral model of the link store, head and free count
// depends on lfbl_pkg and linked_free_block_list
module tb_linked_free_block_list;
  import lfbl_pkg::*;

  localparam int IDLE_LIMIT = 10000;
  localparam int RAND_ITEMS = 800;
  localparam int DRAIN_WAIT = 8;

  typedef struct {
    logic [IDX_W-1:0] given;
    status_e          status;
    logic [IDX_W-1:0] count;
  } alloc_result_t;

  typedef struct {
    action_e          act;
    logic [IDX_W-1:0] blk;
    int               reps;
    bit               typed;
    logic [IDX_W-1:0] e_given;
    status_e          e_stat;
    logic [IDX_W-1:0] e_count;
  } cmd_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic [1:0]       action_i;
  logic [IDX_W-1:0] block_index_i;
  logic             valid_o;
  logic [IDX_W-1:0] given_block_o;
  logic [1:0]       status_o;
  logic [IDX_W-1:0] free_count_o;

  // model state
  logic [IDX_W-1:0] link_mem [NUM_BLOCKS];
  logic [IDX_W-1:0] head_blk;
  int               free_cnt;

  alloc_result_t    pending_q[$];
  logic [IDX_W-1:0] held_q[$];
  int               err_cnt;
  int               idle_cycles;
  int               burst_left;

  // after reset the list is full: pushes of a valid block report full, pops walk 1, 2 and on
  cmd_row_t dir_tab[21] = '{
    '{ACT_PUSH,   10'd5,    1,    1'b1, 10'd0,    STAT_FULL,    10'd1023},
    '{ACT_PUSH,   10'd0,    1,    1'b1, 10'd0,    STAT_INVALID, 10'd1023},
    '{ACT_PUSH,   10'd1023, 1,    1'b1, 10'd0,    STAT_FULL,    10'd1023},
    '{ACT_NONE,   10'd1023, 1,    1'b1, 10'd0,    STAT_OK,      10'd1023},
    '{ACT_POP,    10'd1023, 1,    1'b1, 10'd1,    STAT_OK,      10'd1022},
    '{ACT_POP,    10'd0,    1,    1'b1, 10'd2,    STAT_OK,      10'd1021},
    '{ACT_PUSH,   10'd1023, 1,    1'b1, 10'd0,    STAT_OK,      10'd1022},
    '{ACT_POP,    10'd0,    1,    1'b1, 10'd1023, STAT_OK,      10'd1021},
    '{ACT_PUSH,   10'd0,    1,    1'b1, 10'd0,    STAT_INVALID, 10'd1021},
    '{ACT_PUSH,   10'd1,    1,    1'b1, 10'd0,    STAT_OK,      10'd1022},
    '{ACT_PUSH,   10'd1,    1,    1'b1, 10'd0,    STAT_OK,      10'd1023},
    '{ACT_PUSH,   10'd2,    1,    1'b1, 10'd0,    STAT_FULL,    10'd1023},
    '{ACT_FORMAT, 10'd0,    1,    1'b1, 10'd0,    STAT_OK,      10'd1023},
    '{ACT_POP,    10'd0,    1,    1'b1, 10'd1,    STAT_OK,      10'd1022},
    '{ACT_FORMAT, 10'd1023, 1,    1'b1, 10'd0,    STAT_OK,      10'd1023},
    '{ACT_POP,    10'd0,    1023, 1'b0, 10'd0,    STAT_OK,      10'd0},
    '{ACT_POP,    10'd0,    1,    1'b1, 10'd0,    STAT_EMPTY,   10'd0},
    '{ACT_POP,    10'd1023, 1,    1'b1, 10'd0,    STAT_EMPTY,   10'd0},
    '{ACT_NONE,   10'd0,    1,    1'b1, 10'd0,    STAT_OK,      10'd0},
    '{ACT_PUSH,   10'd512,  1,    1'b1, 10'd0,    STAT_OK,      10'd1},
    '{ACT_POP,    10'd0,    1,    1'b1, 10'd512,  STAT_OK,      10'd0}
  };

  linked_free_block_list u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .block_index_i (block_index_i),
    .valid_o       (valid_o),
    .given_block_o (given_block_o),
    .status_o      (status_o),
    .free_count_o  (free_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void rebuild_links();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      link_mem[i] = (i + 1 < NUM_BLOCKS) ? IDX_W'(i + 1) : '0;
    end
    head_blk = IDX_W'(1);
    free_cnt = NUM_BLOCKS - 1;
  endfunction

  function automatic alloc_result_t predict_alloc(action_e act, logic [IDX_W-1:0] blk);
    alloc_result_t res;
    res.given  = '0;
    res.status = STAT_OK;
    case (act)
      ACT_POP: begin
        if (head_blk == '0 || free_cnt == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.given = head_blk;
          head_blk  = link_mem[head_blk];
          free_cnt  = free_cnt - 1;
        end
      end
      ACT_PUSH: begin
        if (blk == '0 || int'(blk) >= NUM_BLOCKS) begin
          res.status = STAT_INVALID;
        end else if (free_cnt >= NUM_BLOCKS - 1) begin
          res.status = STAT_FULL;
        end else begin
          link_mem[blk] = head_blk;
          head_blk      = blk;
          free_cnt      = free_cnt + 1;
        end
      end
      ACT_FORMAT: rebuild_links();
      default: ;
    endcase
    res.count = IDX_W'(free_cnt);
    return res;
  endfunction

  task automatic report_err(string what, alloc_result_t want);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("%0t: %s: exp given=%0d status=%0d count=%0d, got given=%0d status=%0d count=%0d",
               $realtime, what, want.given, want.status, want.count,
               given_block_o, status_o, free_count_o);
    end
  endtask

  // one command beat; between bursts of random length the sender idles for a random gap, which may be zero
  task automatic send_cmd(action_e act, logic [IDX_W-1:0] blk, bit typed,
                          logic [IDX_W-1:0] e_given, status_e e_stat,
                          logic [IDX_W-1:0] e_count);
    alloc_result_t pred;
    int            gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    start         <= 1'b1;
    action_i      <= act;
    block_index_i <= blk;
    do @(posedge clk_i); while (busy);
    burst_left--;
    pred = predict_alloc(act, blk);
    // keep a list of blocks handed out so most pushes return a real allocation
    if (act == ACT_FORMAT) begin
      held_q.delete();
    end else if (act == ACT_POP && pred.status == STAT_OK) begin
      held_q.push_back(pred.given);
    end else if (act == ACT_PUSH && pred.status == STAT_OK) begin
      for (int i = 0; i < held_q.size(); i++) begin
        if (held_q[i] == blk) begin
          held_q.delete(i);
          break;
        end
      end
    end
    if (typed) begin
      pred.given  = e_given;
      pred.status = e_stat;
      pred.count  = e_count;
    end
    pending_q.push_back(pred);
  endtask

  always @(posedge clk_i) begin : chk_result
    alloc_result_t want;
    if (rst_ni && valid_o) begin
      if (pending_q.size() == 0) begin
        want.given  = '0;
        want.status = STAT_OK;
        want.count  = '0;
        report_err("result beat with nothing pending", want);
      end else begin
        want = pending_q.pop_front();
        if (given_block_o !== want.given || status_o !== want.status ||
            free_count_o !== want.count) begin
          report_err("result mismatch", want);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || valid_o) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_linked_free_block_list failed");
        $finish;
      end
    end
  end

  initial begin : stim
    int               pop_pct;
    int               pick;
    action_e          act;
    logic [IDX_W-1:0] blk;
    err_cnt       = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    action_i      = ACT_NONE;
    block_index_i = '0;
    rebuild_links();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[r]) begin
      repeat (dir_tab[r].reps) begin
        send_cmd(dir_tab[r].act, dir_tab[r].blk, dir_tab[r].typed,
                 dir_tab[r].e_given, dir_tab[r].e_stat, dir_tab[r].e_count);
      end
    end

    // phases lean toward pops or pushes so the count swings to both ends
    pop_pct = 30;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0) pop_pct = ($urandom_range(0, 1) == 1) ? 70 : 30;
      pick = $urandom_range(0, 99);
      blk  = IDX_W'($urandom_range(0, NUM_BLOCKS - 1));
      if (pick < 1) begin
        act = ACT_FORMAT;
      end else if (pick < 4) begin
        act = ACT_NONE;
      end else if (pick < 4 + pop_pct) begin
        act = ACT_POP;
      end else begin
        act  = ACT_PUSH;
        pick = $urandom_range(0, 99);
        if (pick < 80 && held_q.size() > 0) begin
          blk = held_q[$urandom_range(0, held_q.size() - 1)];
        end else if (pick < 88) begin
          blk = '0;
        end
      end
      send_cmd(act, blk, 1'b0, '0, STAT_OK, '0);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_linked_free_block_list passed");
    end else begin
      $display("tb_linked_free_block_list failed");
    end
    $finish;
  end

endmodule
